>>> rtl/fbct_pkg.sv
`timescale 1ns / 1ps

package fbct_pkg;

    localparam int LIST_DEPTH     = 64;
    localparam int ADDR_BITS      = 16;
    localparam int SIZE_BITS      = ADDR_BITS + 1;
    localparam int END_BITS       = ADDR_BITS + 2;
    localparam int IDX_BITS       = $clog2(LIST_DEPTH);
    localparam int CNT_BITS       = $clog2(LIST_DEPTH + 1);
    localparam int OP_BITS        = 2;
    localparam int TDATA_IN_BITS  = ((2 * ADDR_BITS + 7) / 8) * 8;
    localparam int TDATA_OUT_BITS = ((ADDR_BITS + SIZE_BITS + 7) / 8) * 8;
    localparam int TUSER_OUT_BITS = 2;

    typedef enum logic [OP_BITS-1:0] {
        OP_ADD     = 2'd0,
        OP_RELEASE = 2'd1,
        OP_DUMP    = 2'd2
    } t_op;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_DECIDE,
        ST_MERGE_WR,
        ST_SHDN_RD,
        ST_SHDN_WR,
        ST_SHUP_RD,
        ST_SHUP_WR,
        ST_INS_WR,
        ST_DUMP_RD,
        ST_DUMP_LD,
        ST_DUMP_OUT
    } t_state;

    typedef struct packed {
        logic [ADDR_BITS-1:0] start;
        logic [SIZE_BITS-1:0] size;
    } t_entry;

    typedef struct packed {
        logic                below;
        logic                reach;
        logic [END_BITS-1:0] ends;
    } t_cmp;

endpackage

>>> rtl/fbct_ram.sv
`timescale 1ns / 1ps

module fbct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/fbct_unit.sv
`timescale 1ns / 1ps

module fbct_unit (
    input  fbct_pkg::t_entry                  i_entry,
    input  logic [fbct_pkg::ADDR_BITS-1:0]    i_ns,
    input  logic [fbct_pkg::END_BITS-1:0]     i_ne,
    output fbct_pkg::t_cmp                    o_cmp
);

    logic [fbct_pkg::END_BITS-1:0] ends;
    logic [fbct_pkg::END_BITS-1:0] start_ext;
    logic [fbct_pkg::END_BITS-1:0] ns_ext;

    assign start_ext = {{(fbct_pkg::END_BITS - fbct_pkg::ADDR_BITS){1'b0}}, i_entry.start};
    assign ns_ext    = {{(fbct_pkg::END_BITS - fbct_pkg::ADDR_BITS){1'b0}}, i_ns};
    assign ends      = start_ext
                     + {{(fbct_pkg::END_BITS - fbct_pkg::SIZE_BITS){1'b0}}, i_entry.size};

    assign o_cmp.ends  = ends;
    assign o_cmp.below = (ends < ns_ext);
    assign o_cmp.reach = (start_ext <= i_ne);

endmodule

>>> rtl/fbct_seq.sv
`timescale 1ns / 1ps

module fbct_seq (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_vld,
    output logic                            o_in_rdy,
    input  logic [fbct_pkg::OP_BITS-1:0]    i_op,
    input  logic [fbct_pkg::ADDR_BITS-1:0]  i_ns,
    input  logic [fbct_pkg::ADDR_BITS-1:0]  i_sz,
    output logic                            o_out_vld,
    input  logic                            i_out_rdy,
    output fbct_pkg::t_entry                o_out_entry,
    output logic                            o_out_valid,
    output logic                            o_out_last,
    output logic                            o_ovf,
    output logic                            o_we,
    output logic [fbct_pkg::IDX_BITS-1:0]   o_waddr,
    output fbct_pkg::t_entry                o_wdata,
    output logic [fbct_pkg::IDX_BITS-1:0]   o_raddr,
    input  fbct_pkg::t_entry                i_rdata,
    output logic [fbct_pkg::ADDR_BITS-1:0]  o_ns,
    output logic [fbct_pkg::END_BITS-1:0]   o_ne,
    input  fbct_pkg::t_cmp                  i_cmp
);

    localparam int AB = fbct_pkg::ADDR_BITS;
    localparam int SB = fbct_pkg::SIZE_BITS;
    localparam int EB = fbct_pkg::END_BITS;
    localparam int IB = fbct_pkg::IDX_BITS;
    localparam int CB = fbct_pkg::CNT_BITS;

    fbct_pkg::t_state r_state, n_state;

    logic [CB-1:0]    r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic [AB-1:0]    r_ns, n_ns;
    logic [AB-1:0]    r_sz, n_sz;
    logic [EB-1:0]    r_ne, n_ne;
    logic [CB-1:0]    r_idx, n_idx;
    logic [CB-1:0]    r_lo, n_lo;
    logic [CB-1:0]    r_dst, n_dst;
    logic             r_found, n_found;
    logic             r_join, n_join;
    logic [AB-1:0]    r_ms, n_ms;
    logic [EB-1:0]    r_le, n_le;
    logic             r_out_vld, n_out_vld;
    fbct_pkg::t_entry r_out_entry, n_out_entry;
    logic             r_out_valid, n_out_valid;
    logic             r_out_last, n_out_last;

    logic [EB-1:0]    me;
    logic [EB-1:0]    msz;
    logic [CB-1:0]    dst_m1;
    logic [CB-1:0]    idx_p1;

    assign me     = (r_le > r_ne) ? r_le : r_ne;
    assign msz    = me - {{(EB - AB){1'b0}}, r_ms};
    assign dst_m1 = r_dst - 1'b1;
    assign idx_p1 = r_idx + 1'b1;

    always_comb begin
        n_state = r_state;
        case (r_state)
            fbct_pkg::ST_IDLE: begin
                if (i_in_vld) begin
                    case (fbct_pkg::t_op'(i_op))
                        fbct_pkg::OP_ADD,
                        fbct_pkg::OP_RELEASE: n_state = fbct_pkg::ST_SCAN_RD;
                        fbct_pkg::OP_DUMP: begin
                            n_state = (r_cnt == '0) ? fbct_pkg::ST_DUMP_OUT
                                                    : fbct_pkg::ST_DUMP_RD;
                        end
                        default: n_state = fbct_pkg::ST_IDLE;
                    endcase
                end
            end
            fbct_pkg::ST_SCAN_RD: begin
                n_state = (r_idx == r_cnt) ? fbct_pkg::ST_DECIDE : fbct_pkg::ST_SCAN_CHK;
            end
            fbct_pkg::ST_SCAN_CHK: begin
                if ((!r_found && i_cmp.below) || i_cmp.reach) begin
                    n_state = fbct_pkg::ST_SCAN_RD;
                end else begin
                    n_state = fbct_pkg::ST_DECIDE;
                end
            end
            fbct_pkg::ST_DECIDE: begin
                if (r_join) begin
                    n_state = fbct_pkg::ST_MERGE_WR;
                end else if (r_cnt == CB'(fbct_pkg::LIST_DEPTH)) begin
                    n_state = fbct_pkg::ST_IDLE;
                end else begin
                    n_state = fbct_pkg::ST_SHUP_RD;
                end
            end
            fbct_pkg::ST_MERGE_WR: n_state = fbct_pkg::ST_SHDN_RD;
            fbct_pkg::ST_SHDN_RD: begin
                n_state = (r_idx == r_cnt) ? fbct_pkg::ST_IDLE : fbct_pkg::ST_SHDN_WR;
            end
            fbct_pkg::ST_SHDN_WR: n_state = fbct_pkg::ST_SHDN_RD;
            fbct_pkg::ST_SHUP_RD: begin
                n_state = (r_dst == r_lo) ? fbct_pkg::ST_INS_WR : fbct_pkg::ST_SHUP_WR;
            end
            fbct_pkg::ST_SHUP_WR:  n_state = fbct_pkg::ST_SHUP_RD;
            fbct_pkg::ST_INS_WR:   n_state = fbct_pkg::ST_IDLE;
            fbct_pkg::ST_DUMP_RD:  n_state = fbct_pkg::ST_DUMP_LD;
            fbct_pkg::ST_DUMP_LD:  n_state = fbct_pkg::ST_DUMP_OUT;
            fbct_pkg::ST_DUMP_OUT: begin
                if (i_out_rdy) begin
                    n_state = r_out_last ? fbct_pkg::ST_IDLE : fbct_pkg::ST_DUMP_RD;
                end
            end
            default: n_state = fbct_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt       = r_cnt;
        n_ovf       = r_ovf;
        n_ns        = r_ns;
        n_sz        = r_sz;
        n_ne        = r_ne;
        n_idx       = r_idx;
        n_lo        = r_lo;
        n_dst       = r_dst;
        n_found     = r_found;
        n_join      = r_join;
        n_ms        = r_ms;
        n_le        = r_le;
        n_out_vld   = r_out_vld;
        n_out_entry = r_out_entry;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        o_we        = 1'b0;
        o_waddr     = r_lo[IB-1:0];
        o_wdata     = i_rdata;
        o_raddr     = r_idx[IB-1:0];
        case (r_state)
            fbct_pkg::ST_IDLE: begin
                if (i_in_vld) begin
                    n_ns    = i_ns;
                    n_sz    = i_sz;
                    n_ne    = {{(EB - AB){1'b0}}, i_ns} + {{(EB - AB){1'b0}}, i_sz};
                    n_idx   = '0;
                    n_found = 1'b0;
                    n_join  = 1'b0;
                    if (fbct_pkg::t_op'(i_op) == fbct_pkg::OP_DUMP && r_cnt == '0) begin
                        n_out_entry = '0;
                        n_out_valid = 1'b0;
                        n_out_last  = 1'b1;
                        n_out_vld   = 1'b1;
                    end
                end
            end
            fbct_pkg::ST_SCAN_RD: begin
                if (r_idx == r_cnt && !r_found) begin
                    n_lo = r_idx;
                end
            end
            fbct_pkg::ST_SCAN_CHK: begin
                if (!r_found && i_cmp.below) begin
                    n_idx = idx_p1;
                end else begin
                    if (!r_found) begin
                        n_found = 1'b1;
                        n_lo    = r_idx;
                        n_ms    = (i_rdata.start < r_ns) ? i_rdata.start : r_ns;
                    end
                    if (i_cmp.reach) begin
                        n_join = 1'b1;
                        n_le   = i_cmp.ends;
                        n_idx  = idx_p1;
                    end
                end
            end
            fbct_pkg::ST_DECIDE: begin
                if (!r_join) begin
                    if (r_cnt == CB'(fbct_pkg::LIST_DEPTH)) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_dst = r_cnt;
                    end
                end
            end
            fbct_pkg::ST_MERGE_WR: begin
                o_we          = 1'b1;
                o_wdata.start = r_ms;
                o_wdata.size  = msz[SB-1:0];
                n_dst         = r_lo + 1'b1;
            end
            fbct_pkg::ST_SHDN_RD: begin
                if (r_idx == r_cnt) begin
                    n_cnt = r_dst;
                end
            end
            fbct_pkg::ST_SHDN_WR: begin
                o_we    = 1'b1;
                o_waddr = r_dst[IB-1:0];
                n_idx   = idx_p1;
                n_dst   = r_dst + 1'b1;
            end
            fbct_pkg::ST_SHUP_RD: begin
                o_raddr = dst_m1[IB-1:0];
            end
            fbct_pkg::ST_SHUP_WR: begin
                o_we    = 1'b1;
                o_waddr = r_dst[IB-1:0];
                n_dst   = dst_m1;
            end
            fbct_pkg::ST_INS_WR: begin
                o_we          = 1'b1;
                o_wdata.start = r_ns;
                o_wdata.size  = {1'b0, r_sz};
                n_cnt         = r_cnt + 1'b1;
            end
            fbct_pkg::ST_DUMP_LD: begin
                n_out_entry = i_rdata;
                n_out_valid = 1'b1;
                n_out_last  = (idx_p1 == r_cnt);
                n_out_vld   = 1'b1;
            end
            fbct_pkg::ST_DUMP_OUT: begin
                if (i_out_rdy) begin
                    n_out_vld = 1'b0;
                    n_idx     = idx_p1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= fbct_pkg::ST_IDLE;
            r_cnt     <= '0;
            r_ovf     <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_ovf     <= n_ovf;
            r_out_vld <= n_out_vld;
        end
        r_ns        <= n_ns;
        r_sz        <= n_sz;
        r_ne        <= n_ne;
        r_idx       <= n_idx;
        r_lo        <= n_lo;
        r_dst       <= n_dst;
        r_found     <= n_found;
        r_join      <= n_join;
        r_ms        <= n_ms;
        r_le        <= n_le;
        r_out_entry <= n_out_entry;
        r_out_valid <= n_out_valid;
        r_out_last  <= n_out_last;
    end

    assign o_in_rdy    = (r_state == fbct_pkg::ST_IDLE);
    assign o_out_vld   = r_out_vld;
    assign o_out_entry = r_out_entry;
    assign o_out_valid = r_out_valid;
    assign o_out_last  = r_out_last;
    assign o_ovf       = r_ovf;
    assign o_ns        = r_ns;
    assign o_ne        = r_ne;

endmodule

>>> rtl/free_block_coalescing_table.sv
`timescale 1ns / 1ps
// Insert: scans entries, then moves entries and writes the new or merged one;
//   the pace is set by one access per cycle to the list RAM.
// Dump: each entry is read from the list RAM and sent, waiting on m_axis_tready; empty list gives 1 transaction.
// One item at a time: s_axis_tready is high only in the idle state between items.
// Reset (synchronous, active low) clears count, overflow flag and output valid;
//   list storage is not cleared and needs no clearing pass.

module free_block_coalescing_table (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [fbct_pkg::TDATA_IN_BITS-1:0]    s_axis_tdata,  // block_start, block_size
    input  logic [fbct_pkg::OP_BITS-1:0]          s_axis_tuser,  // op
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [fbct_pkg::TDATA_OUT_BITS-1:0]   m_axis_tdata,  // out_start, out_size
    output logic [fbct_pkg::TUSER_OUT_BITS-1:0]   m_axis_tuser,  // out_valid, overflow_seen
    output logic                                  m_axis_tlast
);

    localparam int AB = fbct_pkg::ADDR_BITS;
    localparam int SB = fbct_pkg::SIZE_BITS;

    logic                          we;
    logic [fbct_pkg::IDX_BITS-1:0] waddr;
    logic [fbct_pkg::IDX_BITS-1:0] raddr;
    fbct_pkg::t_entry              wdata;
    fbct_pkg::t_entry              rdata;
    logic [$bits(fbct_pkg::t_entry)-1:0] rdata_bits;
    logic [AB-1:0]                 ns;
    logic [fbct_pkg::END_BITS-1:0] ne;
    fbct_pkg::t_cmp                cmp;
    fbct_pkg::t_entry              out_entry;
    logic                          out_valid;
    logic                          out_last;
    logic                          ovf;

    fbct_ram #(
        .WIDTH($bits(fbct_pkg::t_entry)),
        .DEPTH(fbct_pkg::LIST_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_bits)
    );

    assign rdata = fbct_pkg::t_entry'(rdata_bits);

    fbct_unit u_unit (
        .i_entry (rdata),
        .i_ns    (ns),
        .i_ne    (ne),
        .o_cmp   (cmp)
    );

    fbct_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_vld    (s_axis_tvalid),
        .o_in_rdy    (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_ns        (s_axis_tdata[AB-1:0]),
        .i_sz        (s_axis_tdata[2*AB-1:AB]),
        .o_out_vld   (m_axis_tvalid),
        .i_out_rdy   (m_axis_tready),
        .o_out_entry (out_entry),
        .o_out_valid (out_valid),
        .o_out_last  (out_last),
        .o_ovf       (ovf),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_raddr     (raddr),
        .i_rdata     (rdata),
        .o_ns        (ns),
        .o_ne        (ne),
        .i_cmp       (cmp)
    );

    assign m_axis_tdata = {{(fbct_pkg::TDATA_OUT_BITS - AB - SB){1'b0}},
                           out_entry.size, out_entry.start};
    assign m_axis_tuser = {ovf, out_valid};
    assign m_axis_tlast = out_last;

endmodule
